// ----- src/mtwg_pkg.sv -----
package mtwg_pkg;

	localparam int unsigned AddrW = 10;

	localparam logic [AddrW-1:0] WORDS    = 10'd624;
	localparam logic [AddrW-1:0] UNSEEDED = 10'd625;
	localparam logic [AddrW:0]   MIDDLE   = 11'd397;

	localparam logic [31:0] TWIST_MATRIX    = 32'h9908_b0df;
	localparam logic [31:0] TEMPER_B        = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C        = 32'hefc6_0000;
	localparam logic [31:0] SEED_MULT       = 32'd69069;
	localparam logic [31:0] ZERO_SEED_SUBST = 32'd1999;

	typedef logic [AddrW-1:0] addr_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_TW_PRIME,
		ST_TW_READ,
		ST_TW_CALC,
		ST_RD_WORD,
		ST_DELIVER
	} state_t;

	// one cycle of traffic to the state RAM: one write, two reads
	typedef struct packed {
		logic        we;
		addr_t       waddr;
		logic [31:0] wdata;
		logic        re_a;
		addr_t       addr_a;
		logic        re_b;
		addr_t       addr_b;
	} ram_req_t;

	function automatic logic [31:0] twist(input logic top, input logic [31:0] nxt,
		input logic [31:0] far_word);
		logic [31:0] mixed;
		mixed = {top, nxt[30:0]};
		return far_word ^ (mixed >> 1) ^ (mixed[0] ? TWIST_MATRIX : 32'd0);
	endfunction

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// ----- src/mtwg_state_ram.sv -----
module mtwg_state_ram (
	input  logic              clk,
	input  mtwg_pkg::ram_req_t req,
	output logic [31:0]       rd_a,
	output logic [31:0]       rd_b
);

	logic [31:0] mem_q [int'(mtwg_pkg::WORDS)];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re_a) begin
			rd_a_q <= mem_q[req.addr_a];
		end
		if (req.re_b) begin
			rd_b_q <= mem_q[req.addr_b];
		end
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

// ----- src/mtwg_out_reg.sv -----
module mtwg_out_reg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [31:0] raw_word,
	input  logic        stall,
	output logic        free,
	output logic        valid,
	output logic [31:0] word
);

	logic        valid_q;
	logic [31:0] word_q;

	assign free = !valid_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= mtwg_pkg::temper(raw_word);
		end
	end

	assign valid = valid_q;
	assign word  = word_q;

endmodule

// ----- src/mersenne_twister_word_generator_core.sv -----
// With the state ready, an accepted request passes through ST_RD_WORD and ST_DELIVER, and
// word_valid rises from the output register; a stalled output word holds it in ST_DELIVER.
// No new request is taken until the sequencer is back in idle. The first request after
// reset seeds all 624 words and regenerates the state before its word is read. A request
// that finds all 624 words used regenerates them through the one twist unit first.
// Reset: sequencer idle, word index unseeded (625), seed register 0; state RAM undefined.
module mersenne_twister_word_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        request_valid,
	output logic        request_stall,
	input  logic        request,
	output logic        word_valid,
	input  logic        word_stall,
	output logic [31:0] word,
	input  logic        seed_valid,
	output logic        seed_ready,
	input  logic [31:0] seed
);

	mtwg_pkg::state_t   state_q, state_d;
	mtwg_pkg::ram_req_t ram_req;
	mtwg_pkg::addr_t    idx_q;
	mtwg_pkg::addr_t    cnt_q;
	logic [31:0]        seed_q;
	logic [31:0]        fill_q;
	logic               top_q;
	logic [31:0]        rd_a;
	logic [31:0]        rd_b;
	logic               out_free;
	logic               out_load;
	logic               req_acc;
	logic [10:0]        far_sum;
	mtwg_pkg::addr_t    far_addr;
	mtwg_pkg::addr_t    next_addr;
	logic               cnt_last;

	assign seed_ready    = 1'b1;
	assign request_stall = (state_q != mtwg_pkg::ST_IDLE);
	assign req_acc       = request_valid && !request_stall;

	assign cnt_last  = (cnt_q == mtwg_pkg::WORDS - 10'd1);
	assign far_sum   = {1'b0, cnt_q} + mtwg_pkg::MIDDLE;
	assign far_addr  = (far_sum >= {1'b0, mtwg_pkg::WORDS}) ?
		10'(far_sum - {1'b0, mtwg_pkg::WORDS}) : far_sum[9:0];
	assign next_addr = cnt_last ? '0 : cnt_q + 10'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtwg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ram_req  = '0;
		out_load = 1'b0;
		unique case (state_q)
			mtwg_pkg::ST_IDLE: begin
				if (req_acc && request) begin
					if (idx_q == mtwg_pkg::UNSEEDED) begin
						state_d = mtwg_pkg::ST_SEED;
					end else if (idx_q == mtwg_pkg::WORDS) begin
						state_d = mtwg_pkg::ST_TW_PRIME;
					end else begin
						state_d = mtwg_pkg::ST_RD_WORD;
					end
				end
			end
			mtwg_pkg::ST_SEED: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cnt_q;
				ram_req.wdata = fill_q;
				if (cnt_last) begin
					state_d = mtwg_pkg::ST_TW_PRIME;
				end
			end
			mtwg_pkg::ST_TW_PRIME: begin
				ram_req.re_a   = 1'b1;
				ram_req.addr_a = '0;
				state_d        = mtwg_pkg::ST_TW_READ;
			end
			mtwg_pkg::ST_TW_READ: begin
				ram_req.re_a   = 1'b1;
				ram_req.addr_a = next_addr;
				ram_req.re_b   = 1'b1;
				ram_req.addr_b = far_addr;
				state_d        = mtwg_pkg::ST_TW_CALC;
			end
			mtwg_pkg::ST_TW_CALC: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cnt_q;
				ram_req.wdata = mtwg_pkg::twist(top_q, rd_a, rd_b);
				state_d       = cnt_last ? mtwg_pkg::ST_RD_WORD : mtwg_pkg::ST_TW_READ;
			end
			mtwg_pkg::ST_RD_WORD: begin
				ram_req.re_a   = 1'b1;
				ram_req.addr_a = idx_q;
				state_d        = mtwg_pkg::ST_DELIVER;
			end
			mtwg_pkg::ST_DELIVER: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = mtwg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mtwg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= mtwg_pkg::UNSEEDED;
			cnt_q  <= '0;
			seed_q <= '0;
		end else begin
			if (seed_valid && seed_ready) begin
				seed_q <= seed;
			end
			unique case (state_q)
				mtwg_pkg::ST_SEED: begin
					cnt_q <= cnt_last ? '0 : cnt_q + 10'd1;
				end
				mtwg_pkg::ST_TW_PRIME: begin
					cnt_q <= '0;
				end
				mtwg_pkg::ST_TW_CALC: begin
					cnt_q <= cnt_last ? '0 : cnt_q + 10'd1;
					if (cnt_last) begin
						idx_q <= '0;
					end
				end
				mtwg_pkg::ST_RD_WORD: begin
					idx_q <= idx_q + 10'd1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload: seed chain and top bit of the current word
	always_ff @(posedge clk) begin
		if (state_q == mtwg_pkg::ST_IDLE) begin
			fill_q <= (seed_q == 32'd0) ? mtwg_pkg::ZERO_SEED_SUBST : seed_q;
		end else if (state_q == mtwg_pkg::ST_SEED) begin
			fill_q <= 32'(fill_q * mtwg_pkg::SEED_MULT);
		end
		// rd_a still holds the old word at cnt_q from the previous read
		if (state_q == mtwg_pkg::ST_TW_READ) begin
			top_q <= rd_a[31];
		end
	end

	mtwg_state_ram u_ram (
		.clk  (clk),
		.req  (ram_req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	mtwg_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.raw_word (rd_a),
		.stall    (word_stall),
		.free     (out_free),
		.valid    (word_valid),
		.word     (word)
	);

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q <= mtwg_pkg::WORDS) || (idx_q == mtwg_pkg::UNSEEDED))
		else $error("word index out of range");

	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (state_q == mtwg_pkg::ST_SEED) || (state_q == mtwg_pkg::ST_TW_CALC))
		else $error("state RAM written outside seeding or twist");

	a_read_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mtwg_pkg::ST_RD_WORD) |-> (idx_q < mtwg_pkg::WORDS))
		else $error("word read with stale state");

	a_req_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && request) |=> (state_q != mtwg_pkg::ST_IDLE))
		else $error("request dropped");
`endif

endmodule
